/* hw/rtl/i2cee_pkg.sv */
// shared types, codes and helpers of the i2c eeprom byte access master
`default_nettype none

package i2cee_pkg;

    // command codes on the input channel
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_TWO_BYTE   = 3'd0;
    localparam logic [2:0] CFG_DEV_SEL    = 3'd1;
    localparam logic [2:0] CFG_BIT_PHASE  = 3'd2;
    localparam logic [2:0] CFG_START_STOP = 3'd3;
    localparam logic [2:0] CFG_ACK_TMO    = 3'd4;
    localparam logic [2:0] CFG_WR_CYCLE   = 3'd5;

    localparam int CFG_DATA_W = 20;
    localparam int PHASE_W    = 20;

    // reset values of the configuration registers
    localparam logic [6:0]  DEV_SEL_RST   = 7'h50;
    localparam logic [9:0]  BIT_PHASE_RST = 10'd2;
    localparam logic [9:0]  SS_RST        = 10'd4;
    localparam logic [9:0]  ACK_TMO_RST   = 10'd250;
    localparam logic [19:0] WR_CYCLE_RST  = 20'd10000;

    // classified command of one tick
    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE
    } op_t;

    // sequencer steps
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_DEV,
        ST_AHI,
        ST_ALO,
        ST_DATA,
        ST_RSTART,
        ST_RDSEL,
        ST_RX,
        ST_STOP,
        ST_WAIT
    } step_t;

    // one queued tick
    typedef struct packed {
        op_t         op;
        logic [15:0] mem_address;
        logic [7:0]  write_data;
        logic        sda_in;
    } tick_t;

    // configuration register set
    typedef struct packed {
        logic        two_byte;
        logic [6:0]  dev_sel;
        logic [9:0]  bit_phase;
        logic [9:0]  start_stop;
        logic [9:0]  ack_tmo;
        logic [19:0] wr_cycle;
    } cfg_t;

    // one result of the sequencer
    typedef struct packed {
        logic        scl_release;
        logic        sda_release;
        logic        busy_res;
        logic        done_res;
        logic [7:0]  read_byte;
        logic        ack_error;
    } result_t;

    // device byte with optional block bits and read select
    function automatic logic [7:0] device_byte(input logic two_byte, input logic [6:0] dev_sel,
                                              input logic [15:0] addr, input logic rd);
        logic [7:0] b;
        b = {dev_sel, 1'b0};
        if (!two_byte) begin
            b = b | {4'd0, addr[10:8], 1'b0};
        end
        return b | {7'd0, rd};
    endfunction

    // a zero tick count counts as one
    function automatic logic [9:0] at_least_one(input logic [9:0] v);
        return (v == 10'd0) ? 10'd1 : v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2c_eeprom_byte_access_master.sv */
// top level of the i2c eeprom byte access master
`default_nettype none

// Single-byte random read and byte write master for a 24Cxx-style I2C EEPROM.
// Every input transaction is one timing tick carrying the sampled SDA level
// and, while idle, an optional read or write command; every tick yields one
// result transaction with the open-drain SCL/SDA levels (1 releases the line),
// busy, a done pulse, the last received byte and the ack error flag. The
// front queue (two entries) accepts one per cycle while not full and the
// sequencer retires one per cycle into the output register while that
// register is empty or m_ready is high, so the rate is one transaction per
// cycle when m_ready stays high; a tick's result passes through the queue
// entry and then the output register. Configuration registers are written
// through cfg_we/cfg_index/cfg_data and take effect on the next tick.
module i2c_eeprom_byte_access_master (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [19:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_command,
    input  wire  [15:0] s_mem_address,
    input  wire  [7:0]  s_write_data,
    input  wire         s_sda_in,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_scl_release,
    output logic        m_sda_release,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_read_byte,
    output logic        m_ack_error
);

    i2cee_pkg::cfg_t    cfg_reg;
    i2cee_pkg::tick_t   q_tick;
    i2cee_pkg::result_t result;
    logic               q_valid, q_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.two_byte   <= 1'b0;
            cfg_reg.dev_sel    <= i2cee_pkg::DEV_SEL_RST;
            cfg_reg.bit_phase  <= i2cee_pkg::BIT_PHASE_RST;
            cfg_reg.start_stop <= i2cee_pkg::SS_RST;
            cfg_reg.ack_tmo    <= i2cee_pkg::ACK_TMO_RST;
            cfg_reg.wr_cycle   <= i2cee_pkg::WR_CYCLE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                i2cee_pkg::CFG_TWO_BYTE:   cfg_reg.two_byte   <= cfg_data[0];
                i2cee_pkg::CFG_DEV_SEL:    cfg_reg.dev_sel    <= cfg_data[6:0];
                i2cee_pkg::CFG_BIT_PHASE:  cfg_reg.bit_phase  <= cfg_data[9:0];
                i2cee_pkg::CFG_START_STOP: cfg_reg.start_stop <= cfg_data[9:0];
                i2cee_pkg::CFG_ACK_TMO:    cfg_reg.ack_tmo    <= cfg_data[9:0];
                i2cee_pkg::CFG_WR_CYCLE:   cfg_reg.wr_cycle   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // tick queue
    i2cee_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_mem_address (s_mem_address),
        .s_write_data  (s_write_data),
        .s_sda_in      (s_sda_in),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_tick        (q_tick)
    );

    // bus sequencer
    i2cee_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_tick   (q_tick),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_scl_release = result.scl_release;
    assign m_sda_release = result.sda_release;
    assign m_busy_res    = result.busy_res;
    assign m_done_res    = result.done_res;
    assign m_read_byte   = result.read_byte;
    assign m_ack_error   = result.ack_error;

endmodule

`default_nettype wire

/* hw/rtl/i2cee_front.sv */
// front part: accepts tick transactions, classifies the command, queues them
`default_nettype none

module i2cee_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire  [1:0]           s_command,
    input  wire  [15:0]          s_mem_address,
    input  wire  [7:0]           s_write_data,
    input  wire                  s_sda_in,
    output logic                 q_valid,
    input  wire                  q_ready,
    output i2cee_pkg::tick_t     q_tick
);

    localparam int DEPTH = 2;

    i2cee_pkg::tick_t entry_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    i2cee_pkg::tick_t in_tick;
    logic             push, pop;

    // classify the command code; code 3 counts as no command
    always_comb begin
        in_tick.mem_address = s_mem_address;
        in_tick.write_data  = s_write_data;
        in_tick.sda_in      = s_sda_in;
        unique case (s_command)
            i2cee_pkg::CMD_READ:  in_tick.op = i2cee_pkg::OP_READ;
            i2cee_pkg::CMD_WRITE: in_tick.op = i2cee_pkg::OP_WRITE;
            default:              in_tick.op = i2cee_pkg::OP_NONE;
        endcase
    end

    assign s_ready = (count_reg != 2'(DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_tick  = entry_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // queue pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_tick;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/i2cee_engine.sv */
// back part: bus sequencer that runs one tick per transaction and holds the result
`default_nettype none

module i2cee_engine (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  i2cee_pkg::cfg_t      cfg,
    input  wire                  q_valid,
    output logic                 q_ready,
    input  i2cee_pkg::tick_t     q_tick,
    output logic                 m_valid,
    input  wire                  m_ready,
    output i2cee_pkg::result_t   m_result
);

    localparam int PW = i2cee_pkg::PHASE_W;

    i2cee_pkg::step_t   step_reg, step_next;
    logic [3:0]         bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic [PW-1:0]      pc_reg, pc_next;
    logic [15:0]        addr_reg, addr_next;
    logic [7:0]         data_reg, data_next;
    logic               is_wr_reg, is_wr_next;
    logic [7:0]         rx_reg, rx_next;
    logic               err_reg, err_next;
    logic               out_valid_reg;
    i2cee_pkg::result_t out_reg, res_next;
    logic               advance;

    logic [9:0]         bp, ss, to;
    logic [PW:0]        pc_inc, pc_ext, bp_ext, ss_ext;
    logic               scl, sda, busy, done, half;

    assign q_ready  = !out_valid_reg || m_ready;
    assign advance  = q_valid && q_ready;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    assign bp     = i2cee_pkg::at_least_one(cfg.bit_phase);
    assign ss     = i2cee_pkg::at_least_one(cfg.start_stop);
    assign to     = i2cee_pkg::at_least_one(cfg.ack_tmo);
    assign bp_ext = (PW+1)'(bp);
    assign ss_ext = (PW+1)'(ss);

    // one tick of the sequencer
    always_comb begin
        step_next  = step_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pc_next    = pc_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        is_wr_next = is_wr_reg;
        rx_next    = rx_reg;
        err_next   = err_reg;
        scl        = 1'b1;
        sda        = 1'b1;
        done       = 1'b0;
        half       = 1'b0;

        // latch a new command while idle
        if (step_reg == i2cee_pkg::ST_IDLE && q_tick.op != i2cee_pkg::OP_NONE) begin
            addr_next  = q_tick.mem_address;
            data_next  = q_tick.write_data;
            is_wr_next = (q_tick.op == i2cee_pkg::OP_WRITE);
            err_next   = 1'b0;
            if (q_tick.op == i2cee_pkg::OP_READ) begin
                rx_next = 8'd0;
            end
            step_next  = i2cee_pkg::ST_START;
            bit_next   = 4'd0;
            pc_next    = '0;
            shift_next = 8'd0;
        end
        busy   = (step_next != i2cee_pkg::ST_IDLE);
        pc_ext = (PW+1)'(pc_next);
        pc_inc = pc_ext + (PW+1)'(1);

        unique case (step_next)
            i2cee_pkg::ST_IDLE: begin
            end
            i2cee_pkg::ST_START: begin
                if (pc_ext >= ss_ext) sda = 1'b0;
                pc_next = pc_inc[PW-1:0];
                if (pc_inc >= (ss_ext << 1)) begin
                    step_next  = i2cee_pkg::ST_DEV;
                    bit_next   = 4'd0;
                    pc_next    = '0;
                    shift_next = i2cee_pkg::device_byte(cfg.two_byte, cfg.dev_sel,
                                                        addr_next, 1'b0);
                end
            end
            i2cee_pkg::ST_DEV, i2cee_pkg::ST_AHI, i2cee_pkg::ST_ALO,
            i2cee_pkg::ST_DATA, i2cee_pkg::ST_RDSEL: begin
                half = (pc_ext >= bp_ext);
                scl  = half;
                if (bit_next < 4'd8) begin
                    // shift out one bit
                    sda     = shift_next[7];
                    pc_next = pc_inc[PW-1:0];
                    if (pc_inc >= (bp_ext << 1)) begin
                        shift_next = {shift_next[6:0], 1'b0};
                        bit_next   = bit_next + 4'd1;
                        pc_next    = '0;
                    end
                end else if (!half) begin
                    pc_next = pc_inc[PW-1:0];
                end else if (!q_tick.sda_in) begin
                    // ack seen: choose the next byte
                    bit_next = 4'd0;
                    pc_next  = '0;
                    priority case (step_next)
                        i2cee_pkg::ST_DEV: begin
                            if (cfg.two_byte) begin
                                step_next  = i2cee_pkg::ST_AHI;
                                shift_next = addr_next[15:8];
                            end else begin
                                step_next  = i2cee_pkg::ST_ALO;
                                shift_next = addr_next[7:0];
                            end
                        end
                        i2cee_pkg::ST_AHI: begin
                            step_next  = i2cee_pkg::ST_ALO;
                            shift_next = addr_next[7:0];
                        end
                        i2cee_pkg::ST_ALO: begin
                            if (is_wr_next) begin
                                step_next  = i2cee_pkg::ST_DATA;
                                shift_next = data_next;
                            end else begin
                                step_next  = i2cee_pkg::ST_RSTART;
                                shift_next = 8'd0;
                            end
                        end
                        i2cee_pkg::ST_RDSEL: begin
                            step_next  = i2cee_pkg::ST_RX;
                            shift_next = 8'd0;
                        end
                        default: begin
                            step_next  = i2cee_pkg::ST_STOP;
                            shift_next = 8'd0;
                        end
                    endcase
                end else if (pc_inc >= (PW+1)'(to) + bp_ext) begin
                    // ack timeout: abort with a stop
                    err_next   = 1'b1;
                    step_next  = i2cee_pkg::ST_STOP;
                    bit_next   = 4'd0;
                    pc_next    = '0;
                    shift_next = 8'd0;
                end else begin
                    pc_next = pc_inc[PW-1:0];
                end
            end
            i2cee_pkg::ST_RSTART: begin
                if (pc_ext < bp_ext) scl = 1'b0;
                else if (pc_ext >= bp_ext + ss_ext) sda = 1'b0;
                pc_next = pc_inc[PW-1:0];
                if (pc_inc >= bp_ext + (ss_ext << 1)) begin
                    step_next  = i2cee_pkg::ST_RDSEL;
                    bit_next   = 4'd0;
                    pc_next    = '0;
                    shift_next = i2cee_pkg::device_byte(cfg.two_byte, cfg.dev_sel,
                                                        addr_next, 1'b1);
                end
            end
            i2cee_pkg::ST_RX: begin
                scl     = (pc_ext >= bp_ext);
                pc_next = pc_inc[PW-1:0];
                if (pc_inc >= (bp_ext << 1)) begin
                    if (bit_next < 4'd8) begin
                        // sample one data bit at the end of scl high
                        shift_next = {shift_next[6:0], q_tick.sda_in};
                        bit_next   = bit_next + 4'd1;
                        pc_next    = '0;
                        if (bit_next == 4'd8) rx_next = shift_next;
                    end else begin
                        step_next  = i2cee_pkg::ST_STOP;
                        bit_next   = 4'd0;
                        pc_next    = '0;
                        shift_next = 8'd0;
                    end
                end
            end
            i2cee_pkg::ST_STOP: begin
                if (pc_ext < ss_ext) begin
                    scl = 1'b0;
                    sda = 1'b0;
                end else if (pc_ext < (ss_ext << 1)) begin
                    sda = 1'b0;
                end
                pc_next = pc_inc[PW-1:0];
                if (pc_inc >= (ss_ext << 1) + ss_ext) begin
                    bit_next   = 4'd0;
                    pc_next    = '0;
                    shift_next = 8'd0;
                    if (is_wr_next && !err_next && cfg.wr_cycle != 20'd0) begin
                        step_next = i2cee_pkg::ST_WAIT;
                    end else begin
                        step_next = i2cee_pkg::ST_IDLE;
                        done      = 1'b1;
                    end
                end
            end
            i2cee_pkg::ST_WAIT: begin
                pc_next = pc_inc[PW-1:0];
                if (pc_inc >= (PW+1)'(cfg.wr_cycle)) begin
                    step_next  = i2cee_pkg::ST_IDLE;
                    bit_next   = 4'd0;
                    pc_next    = '0;
                    shift_next = 8'd0;
                    done       = 1'b1;
                end
            end
            default: begin
                step_next  = i2cee_pkg::ST_IDLE;
                bit_next   = 4'd0;
                pc_next    = '0;
                shift_next = 8'd0;
            end
        endcase

        res_next.scl_release = scl;
        res_next.sda_release = sda;
        res_next.busy_res    = busy;
        res_next.done_res    = done;
        res_next.read_byte   = rx_next;
        res_next.ack_error   = err_next;
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= i2cee_pkg::ST_IDLE;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            pc_reg    <= '0;
            addr_reg  <= 16'd0;
            data_reg  <= 8'd0;
            is_wr_reg <= 1'b0;
            rx_reg    <= 8'd0;
            err_reg   <= 1'b0;
        end else if (advance) begin
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pc_reg    <= pc_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
            is_wr_reg <= is_wr_next;
            rx_reg    <= rx_next;
            err_reg   <= err_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_ready) begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/i2cee_checker.sv */
// port checker of the i2c eeprom byte access master and its bind
`default_nettype none

module i2cee_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_valid,
    input wire        m_ready,
    input wire        m_scl_release,
    input wire        m_sda_release,
    input wire        m_busy_res,
    input wire        m_done_res,
    input wire  [7:0] m_read_byte,
    input wire        m_ack_error
);

    // a stalled result transaction stays valid and holds its byte, done, busy and ack error
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_byte) &&
        $stable(m_done_res) && $stable(m_busy_res) && $stable(m_ack_error))
        else $error("result changed while stalled");

    // done only on a busy tick
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_busy_res)
        else $error("done without busy");

    // idle ticks leave both lines released
    a_idle_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> m_scl_release && m_sda_release)
        else $error("line driven while idle");

endmodule

bind i2c_eeprom_byte_access_master i2cee_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_scl_release (m_scl_release),
    .m_sda_release (m_sda_release),
    .m_busy_res    (m_busy_res),
    .m_done_res    (m_done_res),
    .m_read_byte   (m_read_byte),
    .m_ack_error   (m_ack_error)
);

`default_nettype wire
